FILE: src/mbrs_pkg.sv
// ----------------------------------------------------------------------------
// mbrs_pkg
// shared types, codes and the crc step of the modbus rtu register slave
// ----------------------------------------------------------------------------
package mbrs_pkg;

  localparam int unsigned FrameBytesDef    = 256;
  localparam int unsigned RegisterCountDef = 256;
  localparam int unsigned MaxReadCountDef  = 29;

  localparam logic [7:0]  FUNC_READ_HOLD    = 8'h03;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FUNC_WRITE_MULTI  = 8'd16;
  localparam logic [7:0]  ADDR_BROADCAST    = 8'h00;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h11;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [2:0]  HDR_LAST_READ     = 3'd2;
  localparam logic [2:0]  HDR_LAST_WRITE    = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } mbrs_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } mbrs_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_CHECK, ST_WRITE_ONE,
    ST_MULTI_RD_HI, ST_MULTI_RD_LO, ST_MULTI_WR, ST_EMIT_HDR, ST_READ_REQ,
    ST_READ_HI, ST_READ_LO, ST_EMIT_CRC_LO, ST_EMIT_CRC_HI
  } mbrs_state_e;

  typedef enum logic [2:0] {
    OSEL_HDR, OSEL_REG_HI, OSEL_REG_LO, OSEL_CRC_LO, OSEL_CRC_HI
  } mbrs_osel_e;

  typedef enum logic [1:0] {
    BSEL_SCAN, BSEL_HI, BSEL_LO
  } mbrs_bsel_e;

  typedef struct packed {
    logic       store;
    logic       scan_step;
    logic       tx_init;
    logic       emit;
    mbrs_osel_e osel;
    mbrs_bsel_e bsel;
    logic       hdr_step;
    logic       reg_rd;
    logic       cap_reg_lo;
    logic       cap_buf_hi;
    logic       item_next;
    logic       wr_single;
    logic       wr_multi;
    logic       clr_step;
  } mbrs_cmd_t;

  typedef struct packed {
    logic short_frame;
    logic scan_last;
    logic frame_ok;
    logic func_read;
    logic func_wsingle;
    logic func_wmulti;
    logic read_cnt_bad;
    logic wlen_bad;
    logic cnt_zero;
    logic hdr_last;
    logic item_last;
    logic clr_last;
  } mbrs_stat_t;

  // one byte of crc-16/modbus, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/mbrs_ram.sv
// ----------------------------------------------------------------------------
// mbrs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mbrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mbrs_ctrl.sv
// ----------------------------------------------------------------------------
// mbrs_ctrl
// sequencer for frame intake, frame check, register access and reply
// ----------------------------------------------------------------------------
module mbrs_ctrl
  import mbrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       frame_end_i,
  input  mbrs_stat_t stat_i,
  output mbrs_cmd_t  cmd_o,
  output logic       busy
);

  mbrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && frame_end_i && !stat_i.short_frame) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_last) state_d = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (stat_i.frame_ok) begin
          if (stat_i.func_read && !stat_i.read_cnt_bad) begin
            state_d = ST_EMIT_HDR;
          end else if (stat_i.func_wsingle) begin
            state_d = ST_WRITE_ONE;
          end else if (stat_i.func_wmulti && !stat_i.wlen_bad) begin
            state_d = stat_i.cnt_zero ? ST_EMIT_HDR : ST_MULTI_RD_HI;
          end
        end
      end
      ST_WRITE_ONE:   state_d = ST_EMIT_HDR;
      ST_MULTI_RD_HI: state_d = ST_MULTI_RD_LO;
      ST_MULTI_RD_LO: state_d = ST_MULTI_WR;
      ST_MULTI_WR:    state_d = stat_i.item_last ? ST_EMIT_HDR : ST_MULTI_RD_HI;
      ST_EMIT_HDR: begin
        if (stat_i.hdr_last) state_d = stat_i.func_read ? ST_READ_REQ : ST_EMIT_CRC_LO;
      end
      ST_READ_REQ:    state_d = ST_READ_HI;
      ST_READ_HI:     state_d = ST_READ_LO;
      ST_READ_LO:     state_d = stat_i.item_last ? ST_EMIT_CRC_LO : ST_READ_REQ;
      ST_EMIT_CRC_LO: state_d = ST_EMIT_CRC_HI;
      ST_EMIT_CRC_HI: state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.osel = OSEL_HDR;
    cmd_o.bsel = BSEL_SCAN;
    case (state_q)
      ST_CLEAR:       cmd_o.clr_step = 1'b1;
      ST_IDLE:        cmd_o.store = start;
      ST_SCAN:        cmd_o.scan_step = 1'b1;
      ST_CHECK:       cmd_o.tx_init = 1'b1;
      ST_WRITE_ONE:   cmd_o.wr_single = 1'b1;
      ST_MULTI_RD_HI: cmd_o.bsel = BSEL_HI;
      ST_MULTI_RD_LO: begin
        cmd_o.bsel       = BSEL_LO;
        cmd_o.cap_buf_hi = 1'b1;
      end
      ST_MULTI_WR: begin
        cmd_o.wr_multi  = 1'b1;
        cmd_o.item_next = 1'b1;
      end
      ST_EMIT_HDR: begin
        cmd_o.emit     = 1'b1;
        cmd_o.hdr_step = 1'b1;
      end
      ST_READ_REQ:    cmd_o.reg_rd = 1'b1;
      ST_READ_HI: begin
        cmd_o.emit       = 1'b1;
        cmd_o.osel       = OSEL_REG_HI;
        cmd_o.cap_reg_lo = 1'b1;
      end
      ST_READ_LO: begin
        cmd_o.emit      = 1'b1;
        cmd_o.osel      = OSEL_REG_LO;
        cmd_o.item_next = 1'b1;
      end
      ST_EMIT_CRC_LO: begin
        cmd_o.emit = 1'b1;
        cmd_o.osel = OSEL_CRC_LO;
      end
      ST_EMIT_CRC_HI: begin
        cmd_o.emit = 1'b1;
        cmd_o.osel = OSEL_CRC_HI;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: src/mbrs_dp.sv
// ----------------------------------------------------------------------------
// mbrs_dp
// frame buffer, register store, header capture, crc and reply byte select
// ----------------------------------------------------------------------------
module mbrs_dp
  import mbrs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES    = FrameBytesDef,
  parameter int unsigned REGISTER_COUNT = RegisterCountDef,
  parameter int unsigned MAX_READ_COUNT = MaxReadCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mbrs_cmd_t  cmd_i,
  input  mbrs_in_t   in_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output mbrs_stat_t stat_o,
  output mbrs_out_t  out_o
);

  localparam int unsigned LenW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned BufAw = $clog2(FRAME_BYTES);
  localparam int unsigned RegAw = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  logic [7:0]      slave_q;
  logic [LenW-1:0] len_q, len_inc, n_q, scan_q, scan_last_idx, rd_idx_q;
  logic            rd_vld_q, room;
  logic [7:0]      hdr_q [6];
  logic [7:0]      rx_lo_q, rx_hi_q, hi_q, reg_lo_q;
  logic [15:0]     crc_q, tx_crc_q, addr, cnt, item_q, reg_val;
  logic [2:0]      emit_q;
  logic            oor_q, in_range;
  logic [RegAw-1:0] clr_q;
  logic [16:0]     cur_addr, woff;
  logic [7:0]      buf_rdata, hdr_byte, tx_byte;
  logic [BufAw-1:0] buf_raddr;
  logic            hr_we;
  logic [RegAw-1:0] hr_waddr;
  logic [15:0]     hr_wdata, hr_rdata;

  assign room    = (len_q < LenW'(FRAME_BYTES));
  assign len_inc = room ? len_q + LenW'(1) : len_q;
  assign addr    = {hdr_q[2], hdr_q[3]};
  assign cnt     = {hdr_q[4], hdr_q[5]};
  assign cur_addr = {1'b0, addr} + {1'b0, item_q};
  assign in_range = (cur_addr < 17'(REGISTER_COUNT));
  assign woff      = {item_q, 1'b0};
  assign scan_last_idx = (n_q < LenW'(6)) ? LenW'(5) : n_q - LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q  <= SLAVE_ADDR_RESET;
      len_q    <= '0;
      clr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) slave_q <= cfg_wdata_i;
      if (cmd_i.store) len_q <= in_i.frame_end ? '0 : len_inc;
      if (cmd_i.clr_step) clr_q <= clr_q + RegAw'(1);
      rd_vld_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && in_i.frame_end) begin
      n_q    <= len_inc;
      scan_q <= '0;
      crc_q  <= CRC_INIT;
      item_q <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q   <= scan_q + LenW'(1);
      rd_idx_q <= scan_q;
    end
    if (rd_vld_q) begin
      if (rd_idx_q < n_q - LenW'(2)) crc_q <= crc_byte(crc_q, buf_rdata);
      if (rd_idx_q < LenW'(6)) hdr_q[rd_idx_q[2:0]] <= buf_rdata;
      if (rd_idx_q == n_q - LenW'(2)) rx_lo_q <= buf_rdata;
      if (rd_idx_q == n_q - LenW'(1)) rx_hi_q <= buf_rdata;
    end
    if (cmd_i.tx_init) begin
      tx_crc_q <= CRC_INIT;
      emit_q   <= '0;
    end
    if (cmd_i.hdr_step) emit_q <= emit_q + 3'd1;
    if (cmd_i.emit && cmd_i.osel != OSEL_CRC_LO && cmd_i.osel != OSEL_CRC_HI) begin
      tx_crc_q <= crc_byte(tx_crc_q, tx_byte);
    end
    if (cmd_i.reg_rd) oor_q <= !in_range;
    if (cmd_i.cap_reg_lo) reg_lo_q <= reg_val[7:0];
    if (cmd_i.cap_buf_hi) hi_q <= buf_rdata;
    if (cmd_i.item_next) item_q <= item_q + 16'd1;
  end

  // frame buffer
  always_comb begin
    case (cmd_i.bsel)
      BSEL_HI: buf_raddr = BufAw'(woff + 17'd7);
      BSEL_LO: buf_raddr = BufAw'(woff + 17'd8);
      default: buf_raddr = scan_q[BufAw-1:0];
    endcase
  end

  mbrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store && room),
    .waddr_i (len_q[BufAw-1:0]),
    .wdata_i (in_i.rx_byte),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // holding registers
  always_comb begin
    hr_we    = 1'b0;
    hr_waddr = cur_addr[RegAw-1:0];
    hr_wdata = {hi_q, buf_rdata};
    if (cmd_i.clr_step) begin
      hr_we    = 1'b1;
      hr_waddr = clr_q;
      hr_wdata = '0;
    end else if (cmd_i.wr_single) begin
      hr_we    = in_range;
      hr_wdata = cnt;
    end else if (cmd_i.wr_multi) begin
      hr_we    = in_range;
    end
  end

  mbrs_ram #(.WIDTH(16), .DEPTH(REGISTER_COUNT)) u_hold_regs (
    .clk_i   (clk_i),
    .we_i    (hr_we),
    .waddr_i (hr_waddr),
    .wdata_i (hr_wdata),
    .raddr_i (cur_addr[RegAw-1:0]),
    .rdata_o (hr_rdata)
  );

  assign reg_val = oor_q ? 16'h0000 : hr_rdata;

  always_comb begin
    case (emit_q)
      3'd0:    hdr_byte = slave_q;
      3'd1:    hdr_byte = hdr_q[1];
      3'd2:    hdr_byte = stat_o.func_read ? {cnt[6:0], 1'b0} : hdr_q[2];
      3'd3:    hdr_byte = hdr_q[3];
      3'd4:    hdr_byte = hdr_q[4];
      3'd5:    hdr_byte = hdr_q[5];
      default: hdr_byte = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.osel)
      OSEL_REG_HI: tx_byte = reg_val[15:8];
      OSEL_REG_LO: tx_byte = reg_lo_q;
      OSEL_CRC_LO: tx_byte = tx_crc_q[7:0];
      OSEL_CRC_HI: tx_byte = tx_crc_q[15:8];
      default:     tx_byte = hdr_byte;
    endcase
  end

  assign out_o.tx_byte   = tx_byte;
  assign out_o.last_byte = (cmd_i.osel == OSEL_CRC_HI);

  assign stat_o.short_frame  = (len_inc < LenW'(4));
  assign stat_o.scan_last    = (scan_q == scan_last_idx);
  assign stat_o.frame_ok     = (rx_lo_q == crc_q[7:0]) && (rx_hi_q == crc_q[15:8])
                               && (hdr_q[0] != ADDR_BROADCAST) && (hdr_q[0] == slave_q);
  assign stat_o.func_read    = (hdr_q[1] == FUNC_READ_HOLD);
  assign stat_o.func_wsingle = (hdr_q[1] == FUNC_WRITE_SINGLE);
  assign stat_o.func_wmulti  = (hdr_q[1] == FUNC_WRITE_MULTI);
  assign stat_o.read_cnt_bad = (cnt == 16'd0) || (cnt > 16'(MAX_READ_COUNT));
  assign stat_o.wlen_bad     = (18'd9 + {1'b0, cnt, 1'b0}) > 18'(n_q);
  assign stat_o.cnt_zero     = (cnt == 16'd0);
  assign stat_o.hdr_last     = (emit_q == (stat_o.func_read ? HDR_LAST_READ : HDR_LAST_WRITE));
  assign stat_o.item_last    = (item_q == cnt - 16'd1);
  assign stat_o.clr_last     = (clr_q == RegAw'(REGISTER_COUNT - 1));

endmodule

FILE: src/modbus_rtu_register_slave_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_top
// modbus rtu slave with a holding register store (functions 3, 6 and 16)
// ----------------------------------------------------------------------------
// usage: after reset the block sweeps the register store to zero, one
// register a cycle, with busy high. then each byte is a transfer on start
// while busy is low; a byte without frame_end is taken and leaves busy low.
// on the frame's last byte the block reads the buffered frame back one byte
// a cycle through the buffer ram port, then writes registers (function 16:
// read high byte, read low byte, write, per register; function 6: one write)
// and sends the reply, one byte per cycle, but for function 3 a read request
// comes before each register's two bytes. reply bytes come with out_strobe_o
// for exactly one cycle each and cannot be held off; the receiver must take
// them. busy stays high until the last reply byte has been sent.
module modbus_rtu_register_slave_top
  import mbrs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES    = FrameBytesDef,
  parameter int unsigned REGISTER_COUNT = RegisterCountDef,
  parameter int unsigned MAX_READ_COUNT = MaxReadCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  mbrs_in_t   in_i,
  output logic       out_strobe_o,
  output mbrs_out_t  out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  mbrs_cmd_t  cmd;
  mbrs_stat_t stat;

  // controller: sequences intake, check, register access, reply
  mbrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .frame_end_i (in_i.frame_end),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // datapath: buffer, store, crc, reply byte select
  mbrs_dp #(
    .FRAME_BYTES    (FRAME_BYTES),
    .REGISTER_COUNT (REGISTER_COUNT),
    .MAX_READ_COUNT (MAX_READ_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .out_o       (out_o)
  );

  assign out_strobe_o = cmd.emit;

  // reply bytes only go out while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_strobe_o |-> busy)
    else $error("reply byte while idle");

  // a byte that does not end a frame leaves the block ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !in_i.frame_end) |=> !busy)
    else $error("busy after a mid-frame byte");

  // nothing follows the final reply byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && out_o.last_byte) |=> (!out_strobe_o && !busy))
    else $error("reply continues after last byte");

endmodule
